// ===== rtl/core/rps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rps_pkg;

  // Profile phases as reported on the result channel
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_PREHEAT   = 3'd1,
    PH_SOAK      = 3'd2,
    PH_WELD_HEAT = 3'd3,
    PH_WELD      = 3'd4,
    PH_COOLING   = 3'd5
  } phase_e;

  // Input item commands
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT_TEMP = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREHEAT_TEMP = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOAK_TEMP    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_TEMP    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PREHEAT_END  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SOAK_END     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_END     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_WELD_END     = 4'd7;

  // Field widths
  localparam int unsigned TEMP_W = 10;
  localparam int unsigned TIME_W = 16;
  localparam int unsigned DUTY_W = 15;

  // Register reset values
  localparam logic [TEMP_W-1:0] AMBIENT_RST = 10'd25;
  localparam logic [TEMP_W-1:0] PREHEAT_RST = 10'd150;
  localparam logic [TEMP_W-1:0] SOAK_RST    = 10'd180;
  localparam logic [TEMP_W-1:0] PEAK_RST    = 10'd250;
  localparam logic [TIME_W-1:0] PREHEAT_END_RST = 16'd90;
  localparam logic [TIME_W-1:0] SOAK_END_RST    = 16'd170;
  localparam logic [TIME_W-1:0] RISE_END_RST    = 16'd200;
  localparam logic [TIME_W-1:0] WELD_END_RST    = 16'd230;

  // Cooling phase end time and target
  localparam logic [TIME_W-1:0] COOL_END_TIME = 16'd300;
  localparam logic [TEMP_W-1:0] COOL_TEMP     = 10'd0;

  // Slope divider: one quotient bit per cycle, quotient fits the temperature width
  localparam int unsigned DIV_STEPS = TEMP_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic              command;
    logic signed [15:0] controller_output;
  } in_item_t;

  typedef struct packed {
    phase_e             phase;
    logic [TIME_W-1:0]  elapsed;
    logic [TEMP_W-1:0]  setpoint;
    logic [DUTY_W-1:0]  duty;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/reflow_profile_sequencer_unit.sv =====
// Reflow profile setpoint sequencer.
// Input channel (in_valid_i / in_stall_o, payload in_data_i): one transaction
// per control period, either a start command (enter preheat, elapsed 0) or a
// tick (advance elapsed time, step the phase at its end time).
// Result channel (out_valid_o / out_stall_i, payload out_data_o): exactly one
// transaction per input transaction, carrying phase, elapsed ticks, the
// interpolated setpoint and the clamped heater duty.
// Configuration channel (cfg_valid_i / cfg_ready_o): writes the phase targets
// and end times by index; write only while no transaction is in flight.
// A result is registered in ST_FIN after ST_PREP, ST_DIV and ST_MUL (after ST_PREP
// alone in idle, or for a zero-length phase). The input stalls until then, so a
// new transaction is taken only once the last result is registered. The result
// path runs through the restoring divider for the slope, one quotient bit per
// cycle, followed by one multiply and one add/clamp.
// The output register holds a finished result while the receiver stalls;
// the next input transaction is still taken and its result waits for the
// register to drain. Reset returns the profile to idle with elapsed 0 and
// loads the default profile into the configuration registers.
`timescale 1ns / 1ps
`default_nettype none

module reflow_profile_sequencer_unit import rps_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                 in_valid_i,
  output      logic                 in_stall_o,
  input  wire in_item_t             in_data_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  output      out_item_t            out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } state_e;

  // Configuration registers
  logic [TEMP_W-1:0] ambient_q, preheat_temp_q, soak_temp_q, peak_temp_q;
  logic [TIME_W-1:0] preheat_end_q, soak_end_q, rise_end_q, weld_end_q;

  // Sequencer and profile state
  state_e            state_q;
  phase_e            phase_q;
  logic [TIME_W-1:0] tick_q;
  logic [DUTY_W-1:0] duty_q;
  logic              out_valid_q;
  out_item_t         out_data_q;

  // Interpolation datapath
  logic [TEMP_W-1:0]        t_lo_q, t_hi_q;
  logic                     direct_q;     // result is t_hi without a ramp
  logic                     neg_q;        // slope sign
  logic [TIME_W-1:0]        den_q;
  logic [TIME_W-1:0]        rem_q;
  logic [TEMP_W-1:0]        num_sh_q;     // dividend bits, then quotient
  logic [DIV_CNT_W-1:0]     cnt_q;
  logic signed [TIME_W:0]   off_q;
  logic signed [27:0]       prod_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ambient_q      <= AMBIENT_RST;
      preheat_temp_q <= PREHEAT_RST;
      soak_temp_q    <= SOAK_RST;
      peak_temp_q    <= PEAK_RST;
      preheat_end_q  <= PREHEAT_END_RST;
      soak_end_q     <= SOAK_END_RST;
      rise_end_q     <= RISE_END_RST;
      weld_end_q     <= WELD_END_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_AMBIENT_TEMP: ambient_q      <= cfg_data_i[TEMP_W-1:0];
        CFG_PREHEAT_TEMP: preheat_temp_q <= cfg_data_i[TEMP_W-1:0];
        CFG_SOAK_TEMP:    soak_temp_q    <= cfg_data_i[TEMP_W-1:0];
        CFG_PEAK_TEMP:    peak_temp_q    <= cfg_data_i[TEMP_W-1:0];
        CFG_PREHEAT_END:  preheat_end_q  <= cfg_data_i[TIME_W-1:0];
        CFG_SOAK_END:     soak_end_q     <= cfg_data_i[TIME_W-1:0];
        CFG_RISE_END:     rise_end_q     <= cfg_data_i[TIME_W-1:0];
        CFG_WELD_END:     weld_end_q     <= cfg_data_i[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Phase step on an accepted transaction
  logic [TIME_W-1:0] tick_inc;
  logic [TIME_W-1:0] cur_end;
  phase_e            phase_adv;
  phase_e            phase_d;
  logic [TIME_W-1:0] tick_d;
  logic [DUTY_W-1:0] duty_d;

  assign tick_inc = tick_q + 16'd1;

  always_comb begin
    cur_end   = '0;
    phase_adv = PH_IDLE;
    case (phase_q)
      PH_PREHEAT:   begin cur_end = preheat_end_q; phase_adv = PH_SOAK;      end
      PH_SOAK:      begin cur_end = soak_end_q;    phase_adv = PH_WELD_HEAT; end
      PH_WELD_HEAT: begin cur_end = rise_end_q;    phase_adv = PH_WELD;      end
      PH_WELD:      begin cur_end = weld_end_q;    phase_adv = PH_COOLING;   end
      PH_COOLING:   begin cur_end = COOL_END_TIME; phase_adv = PH_IDLE;      end
      default: ;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    duty_d  = '0;
    if (in_data_i.command == CMD_START) begin
      phase_d = PH_PREHEAT;
      tick_d  = '0;
    end else if (phase_q != PH_IDLE) begin
      tick_d = tick_inc;
      if (tick_inc == cur_end) begin
        phase_d = phase_adv;
      end
      if (phase_d != PH_IDLE && phase_d != PH_COOLING &&
          !in_data_i.controller_output[15]) begin
        duty_d = in_data_i.controller_output[DUTY_W-1:0];
      end
    end
  end

  // Ramp operands of the current phase
  logic [TEMP_W-1:0] sel_t_hi, sel_t_lo;
  logic [TIME_W-1:0] sel_e_hi, sel_e_lo;
  logic signed [TEMP_W:0] num_w;
  logic signed [TIME_W:0] span_w;
  logic [TEMP_W-1:0]      num_abs;
  logic [TIME_W-1:0]      span_abs;

  always_comb begin
    sel_t_hi = ambient_q;
    sel_t_lo = ambient_q;
    sel_e_hi = '0;
    sel_e_lo = '0;
    case (phase_q)
      PH_PREHEAT: begin
        sel_t_hi = preheat_temp_q; sel_t_lo = ambient_q;
        sel_e_hi = preheat_end_q;  sel_e_lo = '0;
      end
      PH_SOAK: begin
        sel_t_hi = soak_temp_q;    sel_t_lo = preheat_temp_q;
        sel_e_hi = soak_end_q;     sel_e_lo = preheat_end_q;
      end
      PH_WELD_HEAT: begin
        sel_t_hi = peak_temp_q;    sel_t_lo = soak_temp_q;
        sel_e_hi = rise_end_q;     sel_e_lo = soak_end_q;
      end
      PH_WELD: begin
        sel_t_hi = peak_temp_q;    sel_t_lo = peak_temp_q;
        sel_e_hi = weld_end_q;     sel_e_lo = rise_end_q;
      end
      PH_COOLING: begin
        sel_t_hi = COOL_TEMP;      sel_t_lo = peak_temp_q;
        sel_e_hi = COOL_END_TIME;  sel_e_lo = weld_end_q;
      end
      default: ;
    endcase
  end

  // Magnitudes fit the unsigned field widths: |num| <= 1023, |span| <= 65535
  assign num_w    = $signed({1'b0, sel_t_hi}) - $signed({1'b0, sel_t_lo});
  assign span_w   = $signed({1'b0, sel_e_hi}) - $signed({1'b0, sel_e_lo});
  assign num_abs  = num_w[TEMP_W]  ? TEMP_W'(-num_w)  : num_w[TEMP_W-1:0];
  assign span_abs = span_w[TIME_W] ? TIME_W'(-span_w) : span_w[TIME_W-1:0];

  // Restoring divider step: one quotient bit per cycle
  logic [TIME_W:0]   trial;
  logic              q_bit;
  logic [TIME_W-1:0] trial_sub;

  assign trial     = {rem_q, num_sh_q[TEMP_W-1]};
  assign trial_sub = trial[TIME_W-1:0] - den_q;
  assign q_bit     = (trial >= {1'b0, den_q});

  // Signed slope, then ramp value and clamp
  logic signed [TEMP_W:0] slope_w;
  logic signed [28:0]     sum_w;
  logic [TEMP_W-1:0]      ramp_w;

  assign slope_w = neg_q ? -$signed({1'b0, num_sh_q}) : $signed({1'b0, num_sh_q});
  assign sum_w   = $signed(29'({1'b0, t_lo_q})) + 29'(prod_q);

  always_comb begin
    if (sum_w[28]) begin
      ramp_w = '0;
    end else if (|sum_w[27:TEMP_W]) begin
      ramp_w = '1;
    end else begin
      ramp_w = sum_w[TEMP_W-1:0];
    end
  end

  // Sequencer, datapath and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      duty_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      t_lo_q      <= '0;
      t_hi_q      <= '0;
      direct_q    <= 1'b0;
      neg_q       <= 1'b0;
      den_q       <= '0;
      rem_q       <= '0;
      num_sh_q    <= '0;
      cnt_q       <= '0;
      off_q       <= '0;
      prod_q      <= '0;
    end else begin
      // Drain the output register unless a new result replaces it below
      if (out_valid_q && !out_stall_i && state_q != ST_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            phase_q <= phase_d;
            tick_q  <= tick_d;
            duty_q  <= duty_d;
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          // Idle selects ambient as the high target
          t_lo_q   <= sel_t_lo;
          t_hi_q   <= sel_t_hi;
          neg_q    <= num_w[TEMP_W] ^ span_w[TIME_W];
          den_q    <= span_abs;
          num_sh_q <= num_abs;
          rem_q    <= '0;
          cnt_q    <= '0;
          off_q    <= $signed({1'b0, tick_q}) - $signed({1'b0, sel_e_lo});
          if (phase_q == PH_IDLE) begin
            direct_q <= 1'b1;
            state_q  <= ST_FIN;
          end else if (span_w == '0) begin
            direct_q <= 1'b1;
            state_q  <= ST_FIN;
          end else begin
            direct_q <= 1'b0;
            state_q  <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q    <= q_bit ? trial_sub : trial[TIME_W-1:0];
          num_sh_q <= {num_sh_q[TEMP_W-2:0], q_bit};
          cnt_q    <= cnt_q + DIV_CNT_W'(1);
          if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_q  <= 28'(slope_w) * 28'(off_q);
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q         <= 1'b1;
            out_data_q.phase    <= phase_q;
            out_data_q.elapsed  <= tick_q;
            out_data_q.setpoint <= direct_q ? t_hi_q : ramp_w;
            out_data_q.duty     <= duty_q;
            state_q             <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== test/reflow_profile_checker.sv =====
`timescale 1ns / 1ps

// Watches the configuration, input and result channels of the reflow
// sequencer, keeps its own copy of the profile state and compares every
// result transaction against the predicted one.
module reflow_profile_checker import rps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_item_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_item_t             out_data_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o,
  output logic [5:0]            phases_seen_o
);

  localparam int     MAX_REPORTS = 20;
  localparam longint TEMP_MAX    = (longint'(1) << TEMP_W) - 1;

  // Shadow copy of the profile registers and the sequencing state
  logic [TEMP_W-1:0] ambient_q, preheat_q, soak_q, peak_q;
  logic [TIME_W-1:0] preheat_end_q, soak_end_q, rise_end_q, weld_end_q;
  phase_e            phase_q;
  logic [TIME_W-1:0] ticks_q;

  // Results predicted but not yet seen on the output
  out_item_t due_reports_q[$];

  // Target temperature at the end of a phase
  function automatic logic [TEMP_W-1:0] target_of(input phase_e p);
    case (p)
      PH_PREHEAT:            return preheat_q;
      PH_SOAK:               return soak_q;
      PH_WELD_HEAT, PH_WELD: return peak_q;
      PH_COOLING:            return COOL_TEMP;
      default:               return ambient_q;
    endcase
  endfunction

  // Cumulative tick count at which a phase ends
  function automatic logic [TIME_W-1:0] end_of(input phase_e p);
    case (p)
      PH_PREHEAT: return preheat_end_q;
      PH_SOAK:    return soak_end_q;
      PH_WELD_HEAT: return rise_end_q;
      PH_WELD:    return weld_end_q;
      PH_COOLING: return COOL_END_TIME;
      default:    return '0;
    endcase
  endfunction

  // Linear ramp from the previous phase target; slope truncates toward zero
  function automatic logic [TEMP_W-1:0] ramp_setpoint(input phase_e p,
                                                      input logic [TIME_W-1:0] t);
    phase_e prev;
    longint tgt_hi, tgt_lo, end_hi, end_lo, tv, slope, v;
    if (p == PH_IDLE) return ambient_q;
    prev   = phase_e'(p - 3'd1);
    tgt_hi = target_of(p);
    tgt_lo = target_of(prev);
    end_hi = end_of(p);
    end_lo = end_of(prev);
    tv     = t;
    if (end_hi == end_lo) begin
      v = tgt_hi;
    end else begin
      slope = (tgt_hi - tgt_lo) / (end_hi - end_lo);
      v = tgt_lo + slope * (tv - end_lo);
    end
    if (v < 0) v = 0;
    if (v > TEMP_MAX) v = TEMP_MAX;
    return v[TEMP_W-1:0];
  endfunction

  // Advance the shadow state by one input transaction
  task automatic step_profile(input in_item_t it, output out_item_t res);
    res = '0;
    if (it.command == CMD_START) begin
      ticks_q = '0;
      phase_q = PH_PREHEAT;
      res.setpoint = ramp_setpoint(phase_q, ticks_q);
    end else if (phase_q == PH_IDLE) begin
      res.setpoint = ambient_q;
    end else begin
      ticks_q = ticks_q + 1'b1;
      if (ticks_q == end_of(phase_q))
        phase_q = (phase_q == PH_COOLING) ? PH_IDLE : phase_e'(phase_q + 3'd1);
      res.setpoint = ramp_setpoint(phase_q, ticks_q);
      if (phase_q != PH_IDLE && phase_q != PH_COOLING)
        res.duty = it.controller_output[15] ? '0 : it.controller_output[DUTY_W-1:0];
    end
    res.phase   = phase_q;
    res.elapsed = ticks_q;
  endtask

  task automatic flag_mismatch(input string what, input int unsigned want_v,
                               input int unsigned got_v);
    fail_count_o++;
    if (fail_count_o <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
  endtask

  // Channel monitor: config shadow, result compare, then prediction
  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    out_item_t got;
    if (!rst_ni) begin
      ambient_q     = AMBIENT_RST;
      preheat_q     = PREHEAT_RST;
      soak_q        = SOAK_RST;
      peak_q        = PEAK_RST;
      preheat_end_q = PREHEAT_END_RST;
      soak_end_q    = SOAK_END_RST;
      rise_end_q    = RISE_END_RST;
      weld_end_q    = WELD_END_RST;
      phase_q       = PH_IDLE;
      ticks_q       = '0;
      due_reports_q.delete();
      fail_count_o  = 0;
      checked_o     = 0;
      phases_seen_o = '0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_AMBIENT_TEMP: ambient_q     = cfg_data_i[TEMP_W-1:0];
          CFG_PREHEAT_TEMP: preheat_q     = cfg_data_i[TEMP_W-1:0];
          CFG_SOAK_TEMP:    soak_q        = cfg_data_i[TEMP_W-1:0];
          CFG_PEAK_TEMP:    peak_q        = cfg_data_i[TEMP_W-1:0];
          CFG_PREHEAT_END:  preheat_end_q = cfg_data_i[TIME_W-1:0];
          CFG_SOAK_END:     soak_end_q    = cfg_data_i[TIME_W-1:0];
          CFG_RISE_END:     rise_end_q    = cfg_data_i[TIME_W-1:0];
          CFG_WELD_END:     weld_end_q    = cfg_data_i[TIME_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (due_reports_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: result transaction with none expected, actual %h", $time, got);
        end else begin
          want = due_reports_q.pop_front();
          if (got.phase !== want.phase)
            flag_mismatch("phase", want.phase, got.phase);
          if (got.elapsed !== want.elapsed)
            flag_mismatch("elapsed", want.elapsed, got.elapsed);
          if (got.setpoint !== want.setpoint)
            flag_mismatch("setpoint", want.setpoint, got.setpoint);
          if (got.duty !== want.duty)
            flag_mismatch("duty", want.duty, got.duty);
          checked_o++;
          phases_seen_o[want.phase] = 1'b1;
        end
      end

      if (in_valid_i && !in_stall_i) begin
        step_profile(in_data_i, want);
        due_reports_q.push_back(want);
      end
    end
    pending_o = due_reports_q.size();
  end

endmodule

// ===== test/reflow_profile_sequencer_unit_tb.sv =====
`timescale 1ns / 1ps

module reflow_profile_sequencer_unit_tb;
  import rps_pkg::*;

  localparam int ITEMS_TARGET   = 550;
  localparam int QUIET_TAIL     = 60;
  localparam int LONG_HOLD      = 150;
  localparam int LONG_RUN_TICKS = 305;
  localparam int STUCK_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 30;

  typedef struct packed {
    logic [15:0] ambient;
    logic [15:0] preheat;
    logic [15:0] soak;
    logic [15:0] peak;
    logic [15:0] preheat_end;
    logic [15:0] soak_end;
    logic [15:0] rise_end;
    logic [15:0] weld_end;
  } profile_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall_o;
  in_item_t              in_data;
  logic                  out_valid_o;
  logic                  out_stall;
  out_item_t             out_data_o;

  int         fail_count, pending, checked;
  logic [5:0] phases_seen;

  // Shared knobs between the sender and receiver processes
  bit idle_on     = 1'b1;
  bit quiet_tail  = 1'b0;
  bit long_run    = 1'b0;
  bit hold_on     = 1'b0;
  bit hold_done   = 1'b0;
  int items_sent  = 0;
  int profiles_loaded = 0;
  int run_ticks   = 0;

  reflow_profile_sequencer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  reflow_profile_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall_o),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .phases_seen_o (phases_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Offer one transaction, optionally after a random gap, and wait for acceptance
  task automatic push_item(input logic cmd, input logic [15:0] ctrl);
    in_item_t it;
    it.command = cmd;
    it.controller_output = ctrl;
    if (idle_on && !quiet_tail && !hold_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    if (items_sent >= ITEMS_TARGET - QUIET_TAIL) quiet_tail = 1'b1;
  endtask

  // Stop offering and wait until every predicted result has been seen
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // Config valid stays high across back-to-back writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic load_profile(input profile_t p);
    write_reg(CFG_AMBIENT_TEMP, p.ambient);
    write_reg(CFG_PREHEAT_TEMP, p.preheat);
    write_reg(CFG_SOAK_TEMP,    p.soak);
    write_reg(CFG_PEAK_TEMP,    p.peak);
    write_reg(CFG_PREHEAT_END,  p.preheat_end);
    write_reg(CFG_SOAK_END,     p.soak_end);
    write_reg(CFG_RISE_END,     p.rise_end);
    write_reg(CFG_WELD_END,     p.weld_end);
    // unmapped index, must be dropped
    write_reg(CFG_IDX_W'(CFG_WELD_END + 1 + $urandom_range(0, 7)), 16'($urandom));
    cfg_valid <= 1'b0;
    profiles_loaded++;
  endtask

  function automatic logic [15:0] stretch_end(input logic [15:0] e, input bit strict);
    if (!strict && $urandom_range(0, 7) == 0) return e;
    return e + 16'($urandom_range(1, 12));
  endfunction

  // Short ascending end times; strict keeps every phase nonzero length
  function automatic profile_t ordered_profile(input bit strict);
    profile_t p;
    p.ambient     = 16'($urandom);
    p.preheat     = 16'($urandom);
    p.soak        = 16'($urandom);
    p.peak        = 16'($urandom);
    p.preheat_end = 16'($urandom_range(1, 40));
    p.soak_end    = stretch_end(p.preheat_end, strict);
    p.rise_end    = stretch_end(p.soak_end, strict);
    p.weld_end    = stretch_end(p.rise_end, strict);
    return p;
  endfunction

  function automatic logic [15:0] rail_temp();
    return {6'($urandom), {10{1'($urandom)}}};
  endfunction

  function automatic logic [15:0] rail_end();
    case ($urandom_range(0, 3))
      0:       return 16'd1;
      1:       return 16'hFFFF;
      2:       return 16'd0;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic profile_t extreme_profile();
    profile_t p;
    p.ambient     = rail_temp();
    p.preheat     = rail_temp();
    p.soak        = rail_temp();
    p.peak        = rail_temp();
    p.preheat_end = rail_end();
    p.soak_end    = rail_end();
    p.rise_end    = rail_end();
    p.weld_end    = rail_end();
    return p;
  endfunction

  // Receiver: random stall bursts plus one long hold-off during the full profile
  initial begin
    out_stall = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_run && !hold_done && run_ticks >= 20) begin
        hold_done = 1'b1;
        hold_on   = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall <= 1'b0;
        hold_on   = 1'b0;
      end else if (idle_on && !quiet_tail && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: too many cycles without any transaction
  initial begin : watchdog
    int stuck;
    stuck = 0;
    wait (rst_ni);
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
          (cfg_valid && cfg_ready_o))
        stuck = 0;
      else
        stuck++;
    end
    $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    profile_t prof;
    bit       long_done;
    long_done = 1'b0;
    rst_ni    = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default profile: tick while idle, start, duty clamp edges
    push_item(CMD_TICK,  16'h7FFF);
    push_item(CMD_START, 16'h8000);
    push_item(CMD_TICK,  16'h7FFF);
    push_item(CMD_TICK,  16'h8000);
    push_item(CMD_TICK,  16'hFFFF);
    push_item(CMD_TICK,  16'h0001);
    settle();

    // One tick per phase, rail temperatures, into cooling
    prof = '{ambient: 16'h0000, preheat: 16'hFFFF, soak: 16'h0000, peak: 16'h03FF,
             preheat_end: 16'd1, soak_end: 16'd2, rise_end: 16'd3, weld_end: 16'd4};
    load_profile(prof);
    push_item(CMD_START, 16'h7FFF);
    repeat (5) push_item(CMD_TICK, 16'h7FFF);
    settle();

    // Falling preheat ramp, then a zero-length soak
    prof = '{ambient: 16'h03FF, preheat: 16'h0000, soak: 16'hFC00 | 16'h03FF,
             peak: 16'h0000, preheat_end: 16'd2, soak_end: 16'd2, rise_end: 16'd1,
             weld_end: 16'hFFFF};
    load_profile(prof);
    push_item(CMD_START, 16'h0000);
    repeat (3) push_item(CMD_TICK, 16'h4000);
    settle();

    // Soak ending before preheat: negative span, setpoint clamps at zero
    prof = '{ambient: 16'h03FF, preheat: 16'h0000, soak: 16'h03FF, peak: 16'h03FF,
             preheat_end: 16'd3, soak_end: 16'd1, rise_end: 16'd2, weld_end: 16'hFFFF};
    load_profile(prof);
    push_item(CMD_START, 16'h1234);
    repeat (5) push_item(CMD_TICK, 16'h8001);

    // Random profiles; one runs to completion with a long output hold
    while (items_sent < ITEMS_TARGET) begin
      settle();
      idle_on = ($urandom_range(0, 3) != 0);
      if (!long_done && items_sent >= 80) begin
        load_profile(ordered_profile(1'b1));
        long_run = 1'b1;
        push_item(CMD_START, 16'($urandom));
        repeat (LONG_RUN_TICKS) begin
          push_item(CMD_TICK, 16'($urandom));
          run_ticks++;
        end
        long_run  = 1'b0;
        long_done = 1'b1;
      end else begin
        if ($urandom_range(0, 4) == 0) load_profile(extreme_profile());
        else load_profile(ordered_profile(1'b0));
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 4)) push_item(1'($urandom), 16'($urandom));
          end else begin
            push_item(CMD_START, 16'($urandom));
            repeat ($urandom_range(0, 45)) push_item(CMD_TICK, 16'($urandom));
          end
        end
      end
    end

    // Drain and verdict
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d input transactions across %0d register settings;",
             items_sent, profiles_loaded);
    $display("%0d results checked, phases (cooling..idle) %b, one %0d-cycle hold.",
             checked, phases_seen, LONG_HOLD);
    if (fail_count == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== reflow_profile_sequencer_unit.f =====
rtl/core/rps_pkg.sv
rtl/core/reflow_profile_sequencer_unit.sv
test/reflow_profile_checker.sv
test/reflow_profile_sequencer_unit_tb.sv
